### design/ppt_pkg.sv
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared constants and types for the projective point transform.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ppt_pkg;

	localparam int PPT_COORD_WIDTH = 32;
	localparam int COEF_W          = 32;
	localparam int CFG_W           = 64;
	localparam int FRAC_ALIGN      = 16;

	typedef enum logic [2:0] {
		REG_ROW0_XY = 3'd0,
		REG_ROW0_T  = 3'd1,
		REG_ROW1_XY = 3'd2,
		REG_ROW1_T  = 3'd3,
		REG_ROW2_XY = 3'd4,
		REG_ROW2_T  = 3'd5
	} reg_idx_t;

	localparam logic [CFG_W-1:0] RST_ROW0_XY = 64'h0010_0000_0000_0000;
	localparam logic [CFG_W-1:0] RST_ROW1_XY = 64'h0000_0000_0010_0000;
	localparam logic [CFG_W-1:0] RST_ROW2_XY = 64'h0;
	localparam logic [COEF_W-1:0] RST_ROW0_T = 32'h0;
	localparam logic [COEF_W-1:0] RST_ROW1_T = 32'h0;
	localparam logic [COEF_W-1:0] RST_ROW2_T = 32'h0010_0000;

	typedef struct packed {
		logic w_zero;
		logic sat;
	} ppt_flags_t;

endpackage

`default_nettype wire

### design/projective_point_transform_top.sv
// ----------------------------------------------------------------------------
// projective_point_transform_top
// 2D point times configured 3x3 homogeneous matrix, divided by w.
//
//  channel | signals                              | direction
//  --------+--------------------------------------+----------
//  in      | in_valid, in_ready, x_in, y_in       | sink
//  out     | out_valid, out_ready, x_out, y_out,  | source
//          | w_zero, saturated                    |
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata      | sink
//
// One transaction per cycle while the output is not stalled; the divider
// resolves one quotient bit per stage.
// The whole pipeline advances together; it halts only while the output holds
// an untaken result, so nothing is dropped or repeated.
// Reset clears valid bits and loads the identity matrix.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module projective_point_transform_top import ppt_pkg::*; #(
	parameter int COORD_WIDTH = PPT_COORD_WIDTH
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic signed [COORD_WIDTH-1:0] x_in,
	input  wire logic signed [COORD_WIDTH-1:0] y_in,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic signed [COORD_WIDTH-1:0]      x_out,
	output logic signed [COORD_WIDTH-1:0]      y_out,
	output logic                               w_zero,
	output logic                               saturated,
	input  wire logic                          cfg_wr_en,
	input  wire logic [2:0]                    cfg_index,
	input  wire logic [CFG_W-1:0]              cfg_wdata
);

	localparam int SW  = COORD_WIDTH + 34;
	localparam int LAT = 2 + SW + FRAC_ALIGN + 2;

	logic [CFG_W-1:0]  row0_xy_q, row1_xy_q, row2_xy_q;
	logic [COEF_W-1:0] row0_t_q, row1_t_q, row2_t_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row0_xy_q <= RST_ROW0_XY;
			row1_xy_q <= RST_ROW1_XY;
			row2_xy_q <= RST_ROW2_XY;
			row0_t_q  <= RST_ROW0_T;
			row1_t_q  <= RST_ROW1_T;
			row2_t_q  <= RST_ROW2_T;
		end else if (cfg_wr_en) begin
			case (reg_idx_t'(cfg_index))
				REG_ROW0_XY: row0_xy_q <= cfg_wdata;
				REG_ROW0_T:  row0_t_q  <= cfg_wdata[COEF_W-1:0];
				REG_ROW1_XY: row1_xy_q <= cfg_wdata;
				REG_ROW1_T:  row1_t_q  <= cfg_wdata[COEF_W-1:0];
				REG_ROW2_XY: row2_xy_q <= cfg_wdata;
				REG_ROW2_T:  row2_t_q  <= cfg_wdata[COEF_W-1:0];
				default: ;
			endcase
		end
	end

	logic signed [COEF_W-1:0] coef [3][3];

	always_comb begin
		coef[0][0] = row0_xy_q[63:32];
		coef[0][1] = row0_xy_q[31:0];
		coef[0][2] = row0_t_q;
		coef[1][0] = row1_xy_q[63:32];
		coef[1][1] = row1_xy_q[31:0];
		coef[1][2] = row1_t_q;
		coef[2][0] = row2_xy_q[63:32];
		coef[2][1] = row2_xy_q[31:0];
		coef[2][2] = row2_t_q;
	end

	logic en;
	logic vld_s [LAT];

	assign en       = !vld_s[LAT-1] || out_ready;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LAT; i++) vld_s[i] <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int i = 1; i < LAT; i++) vld_s[i] <= vld_s[i-1];
		end
	end

	logic signed [SW-1:0] sum [3];

	ppt_mac #(.COORD_WIDTH(COORD_WIDTH)) u_mac (
		.clk  (clk),
		.en   (en),
		.x    (x_in),
		.y    (y_in),
		.coef (coef),
		.sum  (sum)
	);

	logic                   sw_zero;
	logic [COORD_WIDTH-1:0] qx, qy;
	ppt_flags_t             fx, fy;

	assign sw_zero = (sum[2] == '0);

	ppt_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_x (
		.clk     (clk),
		.en      (en),
		.num     (sum[0]),
		.den     (sum[2]),
		.zero_in (sw_zero),
		.quo     (qx),
		.flags   (fx)
	);

	ppt_div #(.COORD_WIDTH(COORD_WIDTH)) u_div_y (
		.clk     (clk),
		.en      (en),
		.num     (sum[1]),
		.den     (sum[2]),
		.zero_in (sw_zero),
		.quo     (qy),
		.flags   (fy)
	);

	assign out_valid = vld_s[LAT-1];
	assign x_out     = qx;
	assign y_out     = qy;
	assign w_zero    = fx.w_zero;
	assign saturated = fx.sat || fy.sat;

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && w_zero |-> !saturated)
		else $error("w_zero with saturated");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && w_zero |-> x_out == '0 && y_out == '0)
		else $error("nonzero output on zero w");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && fx.w_zero != fy.w_zero |-> 1'b0)
		else $error("lane zero flags disagree");

	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input accepted during stall");

endmodule

`default_nettype wire

### design/ppt_mac.sv
// ----------------------------------------------------------------------------
// ppt_mac
// Matrix times homogeneous point: products in s1, row sums in s2.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppt_mac import ppt_pkg::*; #(
	parameter int COORD_WIDTH = PPT_COORD_WIDTH
) (
	input  wire logic                            clk,
	input  wire logic                            en,
	input  wire logic signed [COORD_WIDTH-1:0]   x,
	input  wire logic signed [COORD_WIDTH-1:0]   y,
	input  wire logic signed [COEF_W-1:0]        coef [3][3],
	output logic signed [COORD_WIDTH+33:0]       sum  [3]
);

	localparam int PW = COORD_WIDTH + COEF_W;
	localparam int SW = COORD_WIDTH + 34;

	logic signed [PW-1:0]     px_s1 [3];
	logic signed [PW-1:0]     py_s1 [3];
	logic signed [COEF_W-1:0] t_s1  [3];
	logic signed [SW-1:0]     sum_s2 [3];

	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				px_s1[r]  <= PW'(x) * PW'(coef[r][0]);
				py_s1[r]  <= PW'(y) * PW'(coef[r][1]);
				t_s1[r]   <= coef[r][2];
				sum_s2[r] <= SW'(px_s1[r]) + SW'(py_s1[r]) + (SW'(t_s1[r]) <<< FRAC_ALIGN);
			end
		end
	end

	assign sum = sum_s2;

endmodule

`default_nettype wire

### design/ppt_div.sv
// ----------------------------------------------------------------------------
// ppt_div
// Pipelined restoring divider, one quotient bit per stage, with saturation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ppt_div import ppt_pkg::*; #(
	parameter int COORD_WIDTH = PPT_COORD_WIDTH
) (
	input  wire logic                           clk,
	input  wire logic                           en,
	input  wire logic signed [COORD_WIDTH+33:0] num,
	input  wire logic signed [COORD_WIDTH+33:0] den,
	input  wire logic                           zero_in,
	output logic        [COORD_WIDTH-1:0]       quo,
	output ppt_flags_t                          flags
);

	localparam int SW = COORD_WIDTH + 34;
	localparam int NW = SW + FRAC_ALIGN;

	logic [NW-1:0] num_s [NW+1];
	logic [SW-1:0] den_s [NW+1];
	logic [SW-1:0] rem_s [NW+1];
	logic [NW-1:0] q_s   [NW+1];
	logic          neg_s [NW+1];
	logic          zr_s  [NW+1];

	logic [COORD_WIDTH-1:0] quo_s;
	ppt_flags_t             flags_s;

	always_ff @(posedge clk) begin
		if (en) begin
			num_s[0] <= {(num[SW-1] ? SW'(-num) : SW'(num)), {FRAC_ALIGN{1'b0}}};
			den_s[0] <= den[SW-1] ? SW'(-den) : SW'(den);
			rem_s[0] <= '0;
			q_s[0]   <= '0;
			neg_s[0] <= num[SW-1] ^ den[SW-1];
			zr_s[0]  <= zero_in;
		end
	end

	for (genvar i = 0; i < NW; i++) begin : g_bit
		logic [SW:0] sh;
		logic [SW:0] diff;
		logic        take;

		assign sh   = {rem_s[i], num_s[i][NW-1]};
		assign diff = sh - {1'b0, den_s[i]};
		assign take = sh >= {1'b0, den_s[i]};

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[i+1] <= num_s[i] << 1;
				den_s[i+1] <= den_s[i];
				rem_s[i+1] <= take ? diff[SW-1:0] : sh[SW-1:0];
				q_s[i+1]   <= {q_s[i][NW-2:0], take};
				neg_s[i+1] <= neg_s[i];
				zr_s[i+1]  <= zr_s[i];
			end
		end
	end

	logic [63:0]            q_lo;
	logic                   q_big;
	logic                   q_neg;
	logic [63:0]            limit;
	logic                   sat;
	logic [COORD_WIDTH-1:0] mag;

	always_comb begin
		q_lo  = q_s[NW][63:0];
		q_big = |q_s[NW][NW-1:63];
		q_neg = neg_s[NW] && (q_lo != 64'd0);
		limit = (64'd1 << (COORD_WIDTH - 1)) - (q_neg ? 64'd0 : 64'd1);
		sat   = q_big || (q_lo > limit);
		mag   = sat ? limit[COORD_WIDTH-1:0] : q_lo[COORD_WIDTH-1:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo_s          <= zr_s[NW] ? '0 : (q_neg ? -mag : mag);
			flags_s.w_zero <= zr_s[NW];
			flags_s.sat    <= !zr_s[NW] && sat;
		end
	end

	assign quo   = quo_s;
	assign flags = flags_s;

endmodule

`default_nettype wire
